// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, masked while reset is high
`define RPTA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpta assertion failed");
// clocked check that also holds during reset
`define RPTA_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("rpta assertion failed");
`else
`define RPTA_ASSERT(lbl, clk, rst, prop)
`define RPTA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/rpta_pkg.sv
// ---------------------------------------------------------------------------
// rpta_pkg
// Types, constants and the log table of the pixel tone adjust block.
// ---------------------------------------------------------------------------
`default_nettype none

package rpta_pkg;

   localparam int PIX_W     = 8;
   localparam int FACTOR_W  = 16;
   localparam int FRAC_BITS = 8;
   localparam int SUM_W     = 10;
   localparam int LN_W      = 63;              // ln(255/k), 60 fraction bits
   localparam int LO_W      = 32;
   localparam int HI_W      = LN_W - LO_W;
   localparam int T_W       = LN_W + FACTOR_W - 1;
   localparam int SRCH      = PIX_W;           // one search stage per result bit
   localparam int NSTG      = 3 + SRCH + 1;    // lane stages plus output register
   localparam int CSR_IDX_W = 1;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_GAMMA = 2'd1,
      MODE_LIGHT = 2'd2,
      MODE_SAT   = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] chan_a;
      logic [PIX_W-1:0] chan_b;
      logic [PIX_W-1:0] chan_c;
   } pix_in_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_a;
      logic [PIX_W-1:0] out_b;
      logic [PIX_W-1:0] out_c;
   } pix_out_type;

   typedef struct packed {
      logic [NSTG-1:0] en;                     // stage load enables
   } pipe_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] gam;                   // contrast result
      logic [PIX_W-1:0] simp;                  // none / lightness / saturation
   } lane_res_type;

   typedef logic [LN_W-1:0] ln_tbl_type [256];

   // shift-subtract divide, {quotient, remainder}
   function automatic logic [127:0] udivmod(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return {q, r[63:0]};
   endfunction

   // floor(t * num / den)
   function automatic logic [63:0] scale_frac(logic [63:0] t, logic [63:0] num,
                                              logic [63:0] den);
      logic [127:0] a;
      logic [127:0] b;
      a = udivmod(t, den);
      b = udivmod(a[63:0] * num, den);
      return a[127:64] * num + b[127:64];
   endfunction

   function automatic logic [63:0] atanh_fixed(logic [63:0] num, logic [63:0] den);
      logic [63:0]  pw;
      logic [63:0]  sum;
      logic [127:0] qr;
      pw  = scale_frac(64'd1 << 60, num, den);
      sum = '0;
      for (int n = 1; n < 256 && pw != 0; n += 2) begin
         qr  = udivmod(pw, 64'(n));
         sum = sum + qr[127:64];
         pw  = scale_frac(scale_frac(pw, num, den), num, den);
      end
      return sum;
   endfunction

   function automatic logic [63:0] ln_int(logic [63:0] k, logic [63:0] ln2);
      logic [63:0] e;
      logic [63:0] b;
      e = '0;
      for (int i = 0; i < 8; i++) begin
         if ((64'd1 << (e + 1)) <= k) e = e + 1;
      end
      b = 64'd1 << e;
      return e * ln2 + 64'd2 * atanh_fixed(k - b, k + b);
   endfunction

   function automatic ln_tbl_type build_ln_tbl();
      ln_tbl_type  t;
      logic [63:0] ln2;
      logic [63:0] ln255;
      logic [63:0] v;
      ln2   = 64'd2 * atanh_fixed(64'd1, 64'd3);
      ln255 = ln_int(64'd255, ln2);
      t[0]  = '0;
      for (int k = 1; k < 256; k++) begin
         v    = ln255 - ln_int(64'(k), ln2);
         t[k] = v[LN_W-1:0];
      end
      return t;
   endfunction

   localparam ln_tbl_type LN_TBL = build_ln_tbl();

endpackage

`default_nettype wire

// File: rtl/rpta_lane.sv
// ---------------------------------------------------------------------------
// rpta_lane
// One channel: log lookup, split multiply and an eight-step search for
// contrast; lightness and saturation resolved in the first stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rpta_lane import rpta_pkg::*; (
   input  wire logic                clock,
   input  wire pipe_ctrl_type       ctl,
   input  wire logic [PIX_W-1:0]    p,
   input  wire logic [SUM_W-1:0]    sum,
   input  wire mode_type            mode,
   input  wire logic [FACTOR_W-1:0] factor,
   output lane_res_type             res
);

   localparam int LN_NUM_W = 26;
   localparam int SAT_W    = 28 + 2 * (FRAC_BITS - 8);

   // stage 1
   logic [LN_W-1:0]  lnp_ff;
   logic             spec1_ff;
   logic [PIX_W-1:0] sval1_ff;
   logic [PIX_W-1:0] simp1_ff;
   logic             spec1_in;
   logic [PIX_W-1:0] sval1_in;
   logic [PIX_W-1:0] simp1_in;
   // stage 2
   logic [LO_W+FACTOR_W-2:0] lo_ff;
   logic [HI_W+FACTOR_W-2:0] hi_ff;
   logic             spec2_ff;
   logic [PIX_W-1:0] sval2_ff;
   logic [PIX_W-1:0] simp2_ff;
   // stage 3 and search stages
   logic [T_W-1:0]   t_ff    [SRCH+1];
   logic [PIX_W-1:0] k_ff    [SRCH+1];
   logic             spec_ff [SRCH+1];
   logic [PIX_W-1:0] sval_ff [SRCH+1];
   logic [PIX_W-1:0] simp_ff [SRCH+1];

   logic                        fpos;
   logic signed [LN_NUM_W-1:0]  lnum;
   logic signed [LN_NUM_W-1:0]  lq;
   logic signed [SAT_W-1:0]     snum;
   logic signed [SUM_W:0]       dev;
   logic [SUM_W-1:0]            n2;
   logic [SUM_W+11-1:0]         n3;

   always_comb begin
      fpos = !factor[FACTOR_W-1] && (factor != '0);
      // contrast: non-positive exponent gives full scale, else black stays black
      spec1_in = !fpos || (p == '0);
      sval1_in = fpos ? '0 : '1;

      lnum = $signed({{(LN_NUM_W-PIX_W-FRAC_BITS){1'b0}}, p, {FRAC_BITS{1'b0}}})
           + LN_NUM_W'($signed(LN_NUM_W'(255)) * $signed(factor));
      lq   = lnum >>> FRAC_BITS;

      dev  = $signed({1'b0, SUM_W'(3 * p)}) - $signed({1'b0, sum});
      snum = $signed({{(SAT_W-SUM_W-FRAC_BITS){1'b0}}, SUM_W'(3 * p), {FRAC_BITS{1'b0}}})
           + SAT_W'(SAT_W'(dev) * $signed(factor));
      n2   = SUM_W'(snum >>> FRAC_BITS);
      // n2 < 768, so *683 >> 11 is an exact floor divide by three
      n3   = (SUM_W+11)'(n2) * (SUM_W+11)'(683);

      case (mode)
         MODE_LIGHT: begin
            if (lq < 0)                    simp1_in = '0;
            else if (lq > LN_NUM_W'(255))  simp1_in = '1;
            else                           simp1_in = lq[PIX_W-1:0];
         end
         MODE_SAT: begin
            if (snum < 0)
               simp1_in = '0;
            else if (snum >= $signed(SAT_W'(3) <<< (FRAC_BITS + 8)))
               simp1_in = '1;
            else
               simp1_in = n3[PIX_W+11-1:11];
         end
         default: simp1_in = p;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         lnp_ff   <= LN_TBL[p];
         spec1_ff <= spec1_in;
         sval1_ff <= sval1_in;
         simp1_ff <= simp1_in;
      end
      if (ctl.en[1]) begin
         lo_ff    <= lnp_ff[LO_W-1:0] * factor[FACTOR_W-2:0];
         hi_ff    <= lnp_ff[LN_W-1:LO_W] * factor[FACTOR_W-2:0];
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
         simp2_ff <= simp1_ff;
      end
      if (ctl.en[2]) begin
         t_ff[0]    <= {hi_ff, {LO_W{1'b0}}} + T_W'(lo_ff);
         k_ff[0]    <= '0;
         spec_ff[0] <= spec2_ff;
         sval_ff[0] <= sval2_ff;
         simp_ff[0] <= simp2_ff;
      end
   end

   // result bit j: keep candidate while ln(255/k) * 2^frac still reaches ln(255/p) * F
   for (genvar j = 0; j < SRCH; j++) begin : g_srch
      logic [PIX_W-1:0] cand;
      logic             ge;
      always_comb begin
         cand = k_ff[j] | (PIX_W'(1) << (SRCH - 1 - j));
         ge   = T_W'({LN_TBL[cand], {FRAC_BITS{1'b0}}}) >= t_ff[j];
      end
      always_ff @(posedge clock) begin
         if (ctl.en[3+j]) begin
            t_ff[j+1]    <= t_ff[j];
            k_ff[j+1]    <= ge ? cand : k_ff[j];
            spec_ff[j+1] <= spec_ff[j];
            sval_ff[j+1] <= sval_ff[j];
            simp_ff[j+1] <= simp_ff[j];
         end
      end
   end

   assign res.gam  = spec_ff[SRCH] ? sval_ff[SRCH] : k_ff[SRCH];
   assign res.simp = simp_ff[SRCH];

endmodule

`default_nettype wire

// File: rtl/rpta_merge.sv
// ---------------------------------------------------------------------------
// rpta_merge
// Picks each lane's result by mode and registers the output pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module rpta_merge import rpta_pkg::*; (
   input  wire logic          clock,
   input  wire pipe_ctrl_type ctl,
   input  wire mode_type      mode,
   input  wire lane_res_type  res_a,
   input  wire lane_res_type  res_b,
   input  wire lane_res_type  res_c,
   output pix_out_type        pix
);

   pix_out_type pix_ff;
   pix_out_type pix_in;

   always_comb begin
      case (mode)
         MODE_GAMMA: begin
            pix_in.out_a = res_a.gam;
            pix_in.out_b = res_b.gam;
            pix_in.out_c = res_c.gam;
         end
         default: begin
            pix_in.out_a = res_a.simp;
            pix_in.out_b = res_b.simp;
            pix_in.out_c = res_c.simp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en[NSTG-1]) pix_ff <= pix_in;
   end

   assign pix = pix_ff;

endmodule

`default_nettype wire

// File: rtl/rgb_pixel_tone_adjust.sv
// ---------------------------------------------------------------------------
// rgb_pixel_tone_adjust
// Per-pixel contrast (gamma), lightness or saturation adjust, three lanes.
// ---------------------------------------------------------------------------
// Usage:
//  - req_valid/req_stall/req_data carry one pixel a request; rsp_* carry the
//    adjusted pixel, one response per request, in order.
//  - csr_we/csr_index/csr_wdata write adjust_mode (index 0) and
//    adjust_factor (index 1); write only while no request is in flight.
//  - The pipeline stages are the table lookup, two multiply stages, eight search
//    stages (one per output bit) and the output register.
//  - Throughput is one pixel per clock when rsp_stall is low. Each stage
//    loads when it is empty or the stage after it moves, so bubbles close
//    up and a request is taken while a finished pixel waits at the output.
//  - When rsp_stall holds, the pipeline fills and req_stall rises only once
//    every stage holds a pixel.
//  - Synchronous reset empties the pipeline and clears both registers
//    (mode none, factor zero).
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_tone_adjust import rpta_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pix_in_type           req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output pix_out_type               rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FACTOR_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   mode_type            mode_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [NSTG-1:0]     vld_ff;
   logic [NSTG-1:0]     vld_in;
   pipe_ctrl_type       ctl;
   logic [SUM_W-1:0]    sum;
   lane_res_type        res_a;
   lane_res_type        res_b;
   lane_res_type        res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NONE;
         factor_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:   mode_ff   <= mode_type'(csr_wdata[1:0]);
            REG_FACTOR: factor_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // load enables run back from the output
   always_comb begin
      ctl.en[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int s = NSTG - 2; s >= 0; s--) begin
         ctl.en[s] = !vld_ff[s] || ctl.en[s+1];
      end
      vld_in[0] = ctl.en[0] ? req_valid : vld_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         vld_in[s] = ctl.en[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   assign sum = SUM_W'(req_data.chan_a) + SUM_W'(req_data.chan_b)
              + SUM_W'(req_data.chan_c);

   rpta_lane u_lane_a (
      .clock (clock), .ctl (ctl), .p (req_data.chan_a), .sum (sum),
      .mode (mode_ff), .factor (factor_ff), .res (res_a)
   );

   rpta_lane u_lane_b (
      .clock (clock), .ctl (ctl), .p (req_data.chan_b), .sum (sum),
      .mode (mode_ff), .factor (factor_ff), .res (res_b)
   );

   rpta_lane u_lane_c (
      .clock (clock), .ctl (ctl), .p (req_data.chan_c), .sum (sum),
      .mode (mode_ff), .factor (factor_ff), .res (res_c)
   );

   rpta_merge u_merge (
      .clock (clock), .ctl (ctl), .mode (mode_ff),
      .res_a (res_a), .res_b (res_b), .res_c (res_c), .pix (rsp_data)
   );

   assign req_stall = !ctl.en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   `RPTA_ASSERT(a_free_out_takes_req, clock, reset, !rsp_stall |-> !req_stall)
   `RPTA_ASSERT(a_empty_front_takes_req, clock, reset, !vld_ff[0] |-> !req_stall)
   `RPTA_ASSERT(a_accept_fills_front, clock, reset, req_valid && !req_stall |=> vld_ff[0])
   `RPTA_ASSERT(a_mode_write, clock, reset, csr_we && csr_index == REG_MODE |=> mode_ff == $past(csr_wdata[1:0]))
   `RPTA_ASSERT_NR(a_reset_empties, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire
